FILE: hdl/sskw_pkg.sv
// Shared types, constants and match helpers for the shader source keyword scanner.
// Used by sskw_match and shader_source_keyword_scanner; depends on nothing.
package sskw_pkg;

    localparam int WINDOW_BYTES = 12;
    localparam int PATTERN_MAX  = 12;

    typedef logic [WINDOW_BYTES-1:0][7:0] win_t;
    typedef logic [8*PATTERN_MAX-1:0]     pattern_t;
    typedef logic [3:0]                   flags_t;
    typedef logic [9:0]                   version_t;

    localparam int FLAG_ES   = 0;
    localparam int FLAG_GEO  = 1;
    localparam int FLAG_TESS = 2;
    localparam int FLAG_COMP = 3;

    localparam version_t VERSION_MAX = 10'd1023;
    localparam version_t VERSION_100 = 10'd100;
    localparam version_t VERSION_300 = 10'd300;
    localparam version_t VERSION_310 = 10'd310;
    localparam version_t VERSION_320 = 10'd320;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0a;
    localparam logic [7:0] CH_CR     = 8'h0d;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_9      = 8'h39;
    localparam logic [7:0] CH_SEMI   = 8'h3b;
    localparam logic [7:0] CH_LC_E   = 8'h65;
    localparam logic [7:0] CH_LC_I   = 8'h69;
    localparam logic [7:0] CH_LC_N   = 8'h6e;
    localparam logic [7:0] CH_LC_O   = 8'h6f;
    localparam logic [7:0] CH_LC_R   = 8'h72;
    localparam logic [7:0] CH_LC_S   = 8'h73;
    localparam logic [7:0] CH_LC_V   = 8'h76;

    typedef enum logic [9:0] {
        DIR_IDLE    = 10'b00_0000_0001,
        DIR_HASH    = 10'b00_0000_0010,
        DIR_V       = 10'b00_0000_0100,
        DIR_VE      = 10'b00_0000_1000,
        DIR_VER     = 10'b00_0001_0000,
        DIR_VERS    = 10'b00_0010_0000,
        DIR_VERSI   = 10'b00_0100_0000,
        DIR_VERSIO  = 10'b00_1000_0000,
        DIR_AFTER   = 10'b01_0000_0000,
        DIR_DIGITS  = 10'b10_0000_0000
    } dir_state_t;

    typedef enum logic [2:0] {
        LAY_IDLE  = 3'b001,
        LAY_ARMED = 3'b010,
        LAY_TOKEN = 3'b100
    } lay_state_t;

    typedef enum logic [1:0] {
        KIND_FRAGMENT     = 2'd0,
        KIND_GEOMETRY     = 2'd1,
        KIND_TESSELLATION = 2'd2,
        KIND_COMPUTE      = 2'd3
    } kind_t;

    typedef struct packed {
        flags_t keyword_flags;
        flags_t token_flags;
        logic   patch_tail;
        logic   layout_tail;
    } hits_t;

    function automatic logic is_blank(logic [7:0] b);
        return (b == CH_SPACE) || (b == CH_TAB);
    endfunction

    function automatic logic is_digit(logic [7:0] b);
        return b inside {[CH_0:CH_9]};
    endfunction

    // pattern is right-aligned: its last character sits in the low byte
    function automatic logic tail_is(win_t win, pattern_t pat, int unsigned len);
        logic hit;
        hit = (len <= WINDOW_BYTES);
        for (int k = 0; k < PATTERN_MAX; k++)
        begin
            if ((k < len) && (k < WINDOW_BYTES))
            begin
                if (win[WINDOW_BYTES-1-k] != pat[8*k +: 8])
                    hit = 1'b0;
            end
        end
        return hit;
    endfunction

    function automatic logic token_hit(win_t win, pattern_t pat, int unsigned len);
        logic [7:0] prior;
        prior = CH_NUL;
        if (len + 1 <= WINDOW_BYTES)
            prior = win[WINDOW_BYTES-1-len];
        return (len + 1 <= WINDOW_BYTES) && tail_is(win, pat, len) &&
               (is_blank(prior) || (prior == CH_LPAREN));
    endfunction

    function automatic logic version_ok(version_t v);
        return (v == VERSION_100) || (v == VERSION_300) ||
               (v == VERSION_310) || (v == VERSION_320);
    endfunction

    function automatic version_t add_digit(version_t v, logic [7:0] b);
        logic [13:0] sum;
        sum = {4'b0, v} * 14'd10 + {10'b0, b[3:0]};
        if (sum > {4'b0, VERSION_MAX})
            return VERSION_MAX;
        return sum[9:0];
    endfunction

endpackage

FILE: hdl/sskw_match.sv
// Parallel pattern compare over the shifted history window.
// Depends on sskw_pkg for the window type, hit struct and compare helpers.
module sskw_match
    import sskw_pkg::*;
(
    input  win_t  win,
    output hits_t hits
);

    always_comb
    begin
        hits = '0;

        hits.keyword_flags[FLAG_GEO] = tail_is(win, pattern_t'("EmitVertex"), 10) ||
                                       tail_is(win, pattern_t'("EndPrimitive"), 12) ||
                                       tail_is(win, pattern_t'("max_vertices"), 12);
        hits.keyword_flags[FLAG_TESS] = tail_is(win, pattern_t'("gl_TessL"), 8) ||
                                        tail_is(win, pattern_t'("gl_TessC"), 8);
        hits.keyword_flags[FLAG_COMP] = tail_is(win, pattern_t'("gl_WorkG"), 8) ||
                                        tail_is(win, pattern_t'("gl_Local"), 8) ||
                                        tail_is(win, pattern_t'("gl_Global"), 9) ||
                                        tail_is(win, pattern_t'("gl_NumWork"), 10);

        hits.token_flags[FLAG_GEO] = token_hit(win, pattern_t'("tri"), 3) ||
                                     token_hit(win, pattern_t'("points"), 6) ||
                                     token_hit(win, pattern_t'("line"), 4) ||
                                     token_hit(win, pattern_t'("quads"), 5) ||
                                     token_hit(win, pattern_t'("isolines"), 8);
        hits.token_flags[FLAG_COMP] = token_hit(win, pattern_t'("local_size_"), 11);
        hits.token_flags[FLAG_TESS] = token_hit(win, pattern_t'("vertices"), 8);

        hits.patch_tail  = tail_is(win, pattern_t'("patch"), 5);
        hits.layout_tail = tail_is(win, pattern_t'("layout("), 7);
    end

endmodule

FILE: hdl/shader_source_keyword_scanner.sv
// Top level of the shader source keyword scanner: matcher state and result register.
// Depends on sskw_pkg and sskw_match.
//
// Usage:
//   Source text enters one byte per transfer on the byte channel (source_byte,
//   last_byte, byte_valid/byte_stall). A byte can be taken in every cycle.
//   The transfer that carries last_byte produces one result on the result
//   channel (four flags and shader_kind, result_valid/result_stall); no other
//   transfer produces one. A zero byte ends the scan; later bytes up to the
//   last one are taken and ignored.
//   The result is registered: it is valid the cycle after its last byte is taken.
//   Throughput: one byte per cycle while byte_stall is low.
//   While a result waits under result_stall, further non-last bytes are still
//   taken; byte_stall is raised only for a last byte that would need the
//   occupied result register.
//   After each result, and at reset, the window, matchers and flags clear so
//   that the next source starts fresh. Reset empties the result register.
module shader_source_keyword_scanner
    import sskw_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,

    input  logic [7:0] source_byte,
    input  logic       last_byte,
    input  logic       byte_valid,
    output logic       byte_stall,

    output logic       es_version_seen,
    output logic       geometry_seen,
    output logic       tessellation_seen,
    output logic       compute_seen,
    output logic [1:0] shader_kind,
    output logic       result_valid,
    input  logic       result_stall
);

    win_t       window_reg, window_next, win_shift;
    dir_state_t dir_reg, dir_next;
    version_t   version_reg, version_next;
    lay_state_t lay_reg, lay_next;
    logic       patch_reg, patch_next;
    flags_t     flags_reg, flags_next, flags_final;
    logic       ended_reg, ended_next;
    hits_t      hits;

    logic       result_valid_reg;
    flags_t     result_flags_reg;
    kind_t      result_kind_reg, kind_final;
    logic       accept;

    assign win_shift = {source_byte, window_reg[WINDOW_BYTES-1:1]};

    sskw_match u_match
    (
        .win  (win_shift),
        .hits (hits)
    );

    assign byte_stall = result_valid_reg && result_stall && last_byte;
    assign accept     = byte_valid && !byte_stall;

    always_comb
    begin
        window_next  = window_reg;
        dir_next     = dir_reg;
        version_next = version_reg;
        lay_next     = lay_reg;
        patch_next   = patch_reg;
        flags_next   = flags_reg;
        ended_next   = ended_reg;

        if (!ended_reg && (source_byte == CH_NUL))
        begin
            if (patch_reg)
                flags_next[FLAG_TESS] = 1'b1;
            if ((dir_reg == DIR_DIGITS) && version_ok(version_reg))
                flags_next[FLAG_ES] = 1'b1;
            patch_next = 1'b0;
            dir_next   = DIR_IDLE;
            ended_next = 1'b1;
        end
        else if (!ended_reg)
        begin
            window_next = win_shift;

            if (patch_reg && (is_blank(source_byte) || (source_byte == CH_LF) ||
                              (source_byte == CH_CR) || (source_byte == CH_SEMI) ||
                              (source_byte == CH_LPAREN)))
                flags_next[FLAG_TESS] = 1'b1;
            patch_next = hits.patch_tail;

            case (dir_reg)
                DIR_HASH:
                begin
                    if (source_byte == CH_LC_V)
                        dir_next = DIR_V;
                    else if (!is_blank(source_byte))
                        dir_next = DIR_IDLE;
                end
                DIR_V:      dir_next = (source_byte == CH_LC_E) ? DIR_VE : DIR_IDLE;
                DIR_VE:     dir_next = (source_byte == CH_LC_R) ? DIR_VER : DIR_IDLE;
                DIR_VER:    dir_next = (source_byte == CH_LC_S) ? DIR_VERS : DIR_IDLE;
                DIR_VERS:   dir_next = (source_byte == CH_LC_I) ? DIR_VERSI : DIR_IDLE;
                DIR_VERSI:  dir_next = (source_byte == CH_LC_O) ? DIR_VERSIO : DIR_IDLE;
                DIR_VERSIO: dir_next = (source_byte == CH_LC_N) ? DIR_AFTER : DIR_IDLE;
                DIR_AFTER:
                begin
                    if (is_digit(source_byte))
                    begin
                        version_next = add_digit('0, source_byte);
                        dir_next     = DIR_DIGITS;
                    end
                    else if (!is_blank(source_byte))
                        dir_next = DIR_IDLE;
                end
                DIR_DIGITS:
                begin
                    if (is_digit(source_byte))
                        version_next = add_digit(version_reg, source_byte);
                    else
                    begin
                        if (version_ok(version_reg))
                            flags_next[FLAG_ES] = 1'b1;
                        dir_next = DIR_IDLE;
                    end
                end
                default:    dir_next = DIR_IDLE;
            endcase
            if (source_byte == CH_HASH)
            begin
                dir_next     = DIR_HASH;
                version_next = '0;
            end

            flags_next = flags_next | hits.keyword_flags;

            if (source_byte == CH_LPAREN)
                lay_next = hits.layout_tail ? LAY_ARMED : LAY_IDLE;
            else if ((lay_reg == LAY_ARMED) && !is_blank(source_byte))
                lay_next = LAY_TOKEN;
            else if ((lay_reg == LAY_TOKEN) && is_blank(source_byte))
                lay_next = LAY_IDLE;

            if (lay_next == LAY_TOKEN)
                flags_next = flags_next | hits.token_flags;
        end

        // end of text at the last byte closes a pending patch or version
        flags_final = flags_next;
        if (!ended_next)
        begin
            if (patch_next)
                flags_final[FLAG_TESS] = 1'b1;
            if ((dir_next == DIR_DIGITS) && version_ok(version_next))
                flags_final[FLAG_ES] = 1'b1;
        end

        if (flags_final[FLAG_GEO])
            kind_final = KIND_GEOMETRY;
        else if (flags_final[FLAG_TESS])
            kind_final = KIND_TESSELLATION;
        else if (flags_final[FLAG_COMP])
            kind_final = KIND_COMPUTE;
        else
            kind_final = KIND_FRAGMENT;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg  <= '0;
            dir_reg     <= DIR_IDLE;
            version_reg <= '0;
            lay_reg     <= LAY_IDLE;
            patch_reg   <= 1'b0;
            flags_reg   <= '0;
            ended_reg   <= 1'b0;
        end
        else if (accept)
        begin
            if (last_byte)
            begin
                window_reg  <= '0;
                dir_reg     <= DIR_IDLE;
                version_reg <= '0;
                lay_reg     <= LAY_IDLE;
                patch_reg   <= 1'b0;
                flags_reg   <= '0;
                ended_reg   <= 1'b0;
            end
            else
            begin
                window_reg  <= window_next;
                dir_reg     <= dir_next;
                version_reg <= version_next;
                lay_reg     <= lay_next;
                patch_reg   <= patch_next;
                flags_reg   <= flags_next;
                ended_reg   <= ended_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else if (accept && last_byte)
            result_valid_reg <= 1'b1;
        else if (!result_stall)
            result_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept && last_byte)
        begin
            result_flags_reg <= flags_final;
            result_kind_reg  <= kind_final;
        end
    end

    assign result_valid      = result_valid_reg;
    assign es_version_seen   = result_flags_reg[FLAG_ES];
    assign geometry_seen     = result_flags_reg[FLAG_GEO];
    assign tessellation_seen = result_flags_reg[FLAG_TESS];
    assign compute_seen      = result_flags_reg[FLAG_COMP];
    assign shader_kind       = result_kind_reg;

endmodule

FILE: verif/shader_source_keyword_scanner_test.sv
// Self-checking testbench for shader_source_keyword_scanner: a scoreboard class
// predicts each scan result from the accepted bytes; tasks drive the byte channel
// and a process drives result_stall. Depends on sskw_pkg and the scanner RTL.
module shader_source_keyword_scanner_test
    import sskw_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int ITEM_TARGET     = 950;
    localparam int HOLD_CYCLES     = 400;
    localparam int WATCHDOG_CYCLES = 5000;
    localparam int DRAIN_CYCLES    = 4;

    typedef struct packed {
        logic  es;
        logic  geo;
        logic  tess;
        logic  comp;
        kind_t kind;
    } scan_result_t;

    class keyword_scoreboard;
        logic [7:0]   recent [WINDOW_BYTES];
        dir_state_t   dir;
        version_t     version_acc;
        lay_state_t   lay;
        logic         patch_tail;
        flags_t       found;
        logic         ended;
        scan_result_t pending_scans [$];
        int           errors;
        int           sources;
        int           kind_count [4];
        int           es_count;

        function new();
            clear();
            errors = 0;
            sources = 0;
            es_count = 0;
            foreach (kind_count[k])
                kind_count[k] = 0;
        endfunction

        function void clear();
            foreach (recent[k])
                recent[k] = CH_NUL;
            dir = DIR_IDLE;
            version_acc = '0;
            lay = LAY_IDLE;
            patch_tail = 1'b0;
            found = '0;
            ended = 1'b0;
        endfunction

        function bit blank_char(logic [7:0] b);
            return (b == CH_SPACE) || (b == CH_TAB);
        endfunction

        function bit dec_char(logic [7:0] b);
            return (b >= CH_0) && (b <= CH_9);
        endfunction

        function bit window_ends_with(string s);
            int n;
            n = s.len();
            if (n > WINDOW_BYTES)
                return 1'b0;
            for (int i = 0; i < n; i++)
                if (recent[WINDOW_BYTES-n+i] != s[i])
                    return 1'b0;
            return 1'b1;
        endfunction

        function bit token_at_end(string s);
            int         n;
            logic [7:0] prior;
            n = s.len();
            if (n + 1 > WINDOW_BYTES)
                return 1'b0;
            prior = recent[WINDOW_BYTES-1-n];
            return window_ends_with(s) && (blank_char(prior) || (prior == CH_LPAREN));
        endfunction

        function void push_digit(logic [7:0] b);
            int v;
            v = int'(version_acc) * 10 + int'(b - CH_0);
            version_acc = (v > int'(VERSION_MAX)) ? VERSION_MAX : version_t'(v);
        endfunction

        function void close_directive();
            if (version_acc == VERSION_100 || version_acc == VERSION_300 ||
                version_acc == VERSION_310 || version_acc == VERSION_320)
                found[FLAG_ES] = 1'b1;
        endfunction

        function void finish_source();
            if (patch_tail)
                found[FLAG_TESS] = 1'b1;
            if (dir == DIR_DIGITS)
                close_directive();
            patch_tail = 1'b0;
            dir = DIR_IDLE;
            ended = 1'b1;
        endfunction

        function void shift_in(logic [7:0] b);
            logic [7:0] want;
            for (int i = 0; i < WINDOW_BYTES - 1; i++)
                recent[i] = recent[i+1];
            recent[WINDOW_BYTES-1] = b;

            if (patch_tail && (b == CH_SPACE || b == CH_TAB || b == CH_LF ||
                               b == CH_CR || b == CH_SEMI || b == CH_LPAREN))
                found[FLAG_TESS] = 1'b1;
            patch_tail = window_ends_with("patch");

            want = CH_NUL;
            case (dir)
                DIR_V:      want = "e";
                DIR_VE:     want = "r";
                DIR_VER:    want = "s";
                DIR_VERS:   want = "i";
                DIR_VERSI:  want = "o";
                DIR_VERSIO: want = "n";
                default:    want = CH_NUL;
            endcase
            case (dir)
                DIR_HASH:
                begin
                    if (b == "v")
                        dir = DIR_V;
                    else if (!blank_char(b))
                        dir = DIR_IDLE;
                end
                DIR_V, DIR_VE, DIR_VER, DIR_VERS, DIR_VERSI, DIR_VERSIO:
                begin
                    if (b == want)
                        dir = dir_state_t'(dir << 1);
                    else
                        dir = DIR_IDLE;
                end
                DIR_AFTER:
                begin
                    if (dec_char(b))
                    begin
                        version_acc = '0;
                        push_digit(b);
                        dir = DIR_DIGITS;
                    end
                    else if (!blank_char(b))
                        dir = DIR_IDLE;
                end
                DIR_DIGITS:
                begin
                    if (dec_char(b))
                        push_digit(b);
                    else
                    begin
                        close_directive();
                        dir = DIR_IDLE;
                    end
                end
                default:
                    dir = DIR_IDLE;
            endcase
            if (b == CH_HASH)
            begin
                dir = DIR_HASH;
                version_acc = '0;
            end

            if (window_ends_with("EmitVertex") || window_ends_with("EndPrimitive") ||
                window_ends_with("max_vertices"))
                found[FLAG_GEO] = 1'b1;
            if (window_ends_with("gl_TessL") || window_ends_with("gl_TessC"))
                found[FLAG_TESS] = 1'b1;
            if (window_ends_with("gl_WorkG") || window_ends_with("gl_Local") ||
                window_ends_with("gl_Global") || window_ends_with("gl_NumWork"))
                found[FLAG_COMP] = 1'b1;

            if (b == CH_LPAREN)
                lay = window_ends_with("layout(") ? LAY_ARMED : LAY_IDLE;
            else if (lay == LAY_ARMED)
            begin
                if (!blank_char(b))
                    lay = LAY_TOKEN;
            end
            else if (lay == LAY_TOKEN)
            begin
                if (blank_char(b))
                    lay = LAY_IDLE;
            end
            if (lay == LAY_TOKEN)
            begin
                if (token_at_end("tri") || token_at_end("points") || token_at_end("line") ||
                    token_at_end("quads") || token_at_end("isolines"))
                    found[FLAG_GEO] = 1'b1;
                if (token_at_end("local_size_"))
                    found[FLAG_COMP] = 1'b1;
                if (token_at_end("vertices"))
                    found[FLAG_TESS] = 1'b1;
            end
        endfunction

        function void note_byte(logic [7:0] b, logic last);
            scan_result_t r;
            if (!ended)
            begin
                if (b == CH_NUL)
                    finish_source();
                else
                    shift_in(b);
            end
            if (last)
            begin
                if (!ended)
                    finish_source();
                r.es   = found[FLAG_ES];
                r.geo  = found[FLAG_GEO];
                r.tess = found[FLAG_TESS];
                r.comp = found[FLAG_COMP];
                if (found[FLAG_GEO])
                    r.kind = KIND_GEOMETRY;
                else if (found[FLAG_TESS])
                    r.kind = KIND_TESSELLATION;
                else if (found[FLAG_COMP])
                    r.kind = KIND_COMPUTE;
                else
                    r.kind = KIND_FRAGMENT;
                pending_scans.push_back(r);
                sources++;
                kind_count[r.kind]++;
                if (r.es)
                    es_count++;
                clear();
            end
        endfunction

        function void compare_field(string name, int want, int got);
            if (want != got)
            begin
                $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_result(scan_result_t got);
            scan_result_t want;
            if (pending_scans.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, %s%0d %s%0d %s%0d %s%0d %s%0d",
                         $time, "got es=", got.es, "geo=", got.geo, "tess=", got.tess,
                         "comp=", got.comp, "kind=", got.kind);
                errors++;
                return;
            end
            want = pending_scans.pop_front();
            compare_field("es_version_seen", want.es, got.es);
            compare_field("geometry_seen", want.geo, got.geo);
            compare_field("tessellation_seen", want.tess, got.tess);
            compare_field("compute_seen", want.comp, got.comp);
            compare_field("shader_kind", want.kind, got.kind);
        endfunction
    endclass

    logic       clk;
    logic       rst_n;
    logic [7:0] source_byte;
    logic       last_byte;
    logic       byte_valid;
    logic       byte_stall;
    logic       es_version_seen;
    logic       geometry_seen;
    logic       tessellation_seen;
    logic       compute_seen;
    logic [1:0] shader_kind;
    logic       result_valid;
    logic       result_stall;

    keyword_scoreboard scoreboard;
    logic [7:0]        src_bytes [$];
    int                byte_count;
    int                idle_cycles;
    bit                quiet;
    bit                hold_req;
    bit                hold_active;
    bit                hold_done;

    string keyword_list [9] = '{"EmitVertex", "EndPrimitive", "max_vertices", "gl_TessL",
                                "gl_TessC", "gl_WorkG", "gl_Local", "gl_Global", "gl_NumWork"};
    string token_list [7]   = '{"tri", "points", "line", "quads", "isolines", "local_size_",
                                "vertices"};
    string layout_tails [5] = '{"", ")", " ", "=4)", "angles,"};
    string patch_ends [8]   = '{" ", "\t", "\n", "\r", ";", "(", "x", ""};
    string version_ends [4] = '{"", "\n", " ", ";"};
    string separators [3]   = '{" ", "\n", "\t"};

    shader_source_keyword_scanner u_dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .source_byte       (source_byte),
        .last_byte         (last_byte),
        .byte_valid        (byte_valid),
        .byte_stall        (byte_stall),
        .es_version_seen   (es_version_seen),
        .geometry_seen     (geometry_seen),
        .tessellation_seen (tessellation_seen),
        .compute_seen      (compute_seen),
        .shader_kind       (shader_kind),
        .result_valid      (result_valid),
        .result_stall      (result_stall)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    function automatic string blanks(int max_n);
        string s;
        s = "";
        repeat ($urandom_range(0, max_n))
            if ($urandom_range(0, 1) != 0)
                s = {s, " "};
            else
                s = {s, "\t"};
        return s;
    endfunction

    function automatic string damaged(string s);
        if ($urandom_range(0, 5) == 0)
            s[$urandom_range(0, s.len() - 1)] = byte'($urandom_range(33, 126));
        return s;
    endfunction

    function automatic void push_text(string s);
        for (int i = 0; i < s.len(); i++)
            src_bytes.push_back(s[i]);
    endfunction

    function automatic void add_fragment();
        int    r;
        string s;
        r = $urandom_range(0, 99);
        s = "";
        if (r < 22)
            s = damaged(keyword_list[$urandom_range(0, 8)]);
        else if (r < 44)
            s = {damaged("layout("), blanks(2), damaged(token_list[$urandom_range(0, 6)]),
                 layout_tails[$urandom_range(0, 4)]};
        else if (r < 66)
        begin
            // a stray directive start in front exercises the restart on a new hash
            if ($urandom_range(0, 7) == 0)
                s = "#ver";
            s = {s, "#", blanks(2), damaged("version"), blanks(2)};
            case ($urandom_range(0, 8))
                0: s = {s, "100"};
                1: s = {s, "300"};
                2: s = {s, "310"};
                3: s = {s, "320"};
                4: s = {s, $sformatf("%0d", $urandom_range(0, 999))};
                5: s = {s, $sformatf("%0d", $urandom_range(1024, 99999))};
                6: s = {s, "0", $sformatf("%0d", 300 + 10 * $urandom_range(0, 2))};
                7: s = {s, "99999999"};
                default: s = s;
            endcase
            s = {s, version_ends[$urandom_range(0, 3)]};
        end
        else if (r < 78)
            s = {"patch", patch_ends[$urandom_range(0, 7)]};
        else if (r < 86)
            s = {blanks(3), "\n"};
        else if (r < 96)
            repeat ($urandom_range(1, 8))
                src_bytes.push_back(8'($urandom_range(1, 255)));
        else
            src_bytes.push_back(CH_NUL);
        push_text(s);
    endfunction

    function automatic void build_source();
        src_bytes.delete();
        if ($urandom_range(0, 9) == 0)
            repeat ($urandom_range(1, 6))
                src_bytes.push_back(8'($urandom_range(0, 255)));
        else
            repeat ($urandom_range(1, 3))
            begin
                add_fragment();
                if ($urandom_range(0, 1) != 0)
                    push_text(separators[$urandom_range(0, 2)]);
            end
        if (src_bytes.size() == 0)
            src_bytes.push_back(8'($urandom_range(0, 255)));
    endfunction

    // called in the time step of the previous transfer, or right after reset
    task automatic drive_byte(logic [7:0] b, logic last);
        int gap;
        gap = quiet ? 0 : idle_len();
        if (gap > 0)
        begin
            byte_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        source_byte <= b;
        last_byte   <= last;
        byte_valid  <= 1'b1;
        @(posedge clk);
        while (byte_stall)
            @(posedge clk);
        scoreboard.note_byte(b, last);
        byte_count++;
    endtask

    task automatic send_source();
        for (int i = 0; i < src_bytes.size(); i++)
            drive_byte(src_bytes[i], i == src_bytes.size() - 1);
    endtask

    task automatic drain();
        byte_valid <= 1'b0;
        @(posedge clk);
        while (scoreboard.pending_scans.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin : result_stall_gen
        result_stall = 1'b0;
        hold_active  = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                result_stall <= 1'b1;
                hold_active = 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                result_stall <= 1'b0;
                hold_active = 1'b0;
                hold_req = 1'b0;
            end
            else if (!quiet && $urandom_range(0, 2) == 0)
            begin
                result_stall <= 1'b1;
                repeat (1 + idle_len()) @(posedge clk);
                result_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin : result_monitor
        scan_result_t got;
        if (rst_n && result_valid && !result_stall)
        begin
            got.es   = es_version_seen;
            got.geo  = geometry_seen;
            got.tess = tessellation_seen;
            got.comp = compute_seen;
            got.kind = kind_t'(shader_kind);
            scoreboard.check_result(got);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((byte_valid && !byte_stall) || (result_valid && !result_stall))
                idle_cycles <= 0;
            else
            begin
                idle_cycles <= idle_cycles + 1;
                if (idle_cycles >= WATCHDOG_CYCLES)
                begin
                    $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
                    $display("shader_source_keyword_scanner verification failed");
                    $finish;
                end
            end
        end
    end

    initial
    begin
        scoreboard  = new();
        rst_n       = 1'b0;
        byte_valid  = 1'b0;
        source_byte = 8'h00;
        last_byte   = 1'b0;
        quiet       = 1'b0;
        hold_req    = 1'b0;
        hold_done   = 1'b0;
        byte_count  = 0;
        idle_cycles = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // all-ones byte alone; saturating version after an abandoned directive,
        // then a zero byte with a trailing ignored byte; directive without digits
        src_bytes = '{8'hFF};
        send_source();
        src_bytes.delete();
        push_text("#v#version 3100");
        src_bytes.push_back(CH_NUL);
        push_text("z");
        send_source();
        src_bytes.delete();
        push_text("#version;");
        send_source();
        drain();

        while (byte_count < ITEM_TARGET)
        begin
            if (!hold_done && byte_count > ITEM_TARGET / 3)
            begin
                drain();
                hold_req = 1'b1;
                while (!hold_active)
                    @(posedge clk);
                repeat (8)
                begin
                    src_bytes.delete();
                    repeat ($urandom_range(1, 3))
                        src_bytes.push_back(8'($urandom_range(1, 255)));
                    send_source();
                end
                hold_done = 1'b1;
            end
            quiet = (byte_count > ITEM_TARGET / 2) && (byte_count < ITEM_TARGET / 2 + 120);
            build_source();
            send_source();
            if ($urandom_range(0, 11) == 0)
                drain();
        end
        quiet = 1'b0;
        drain();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Ran %0d bytes in %0d sources: %0d fragment, %0d geometry, %0d tessellation,",
                 byte_count, scoreboard.sources, scoreboard.kind_count[KIND_FRAGMENT],
                 scoreboard.kind_count[KIND_GEOMETRY], scoreboard.kind_count[KIND_TESSELLATION]);
        $display("%0d compute, %0d with an ES version; %0d mismatches.",
                 scoreboard.kind_count[KIND_COMPUTE], scoreboard.es_count, scoreboard.errors);
        if (scoreboard.errors == 0)
            $display("shader_source_keyword_scanner verification clean");
        else
            $display("shader_source_keyword_scanner verification failed");
        $finish;
    end

endmodule
